// ----- hw/rtl/sitda_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

	localparam int VALUE_W       = 32;
	localparam int CH_W          = 8;
	localparam int RADIX         = 10;
	localparam int DIGITS        = 10;
	localparam int NIBBLE_W      = 4;
	localparam int BCD_W         = DIGITS * NIBBLE_W;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(CONV_STEPS);
	localparam int POS_W         = $clog2(DIGITS);
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CH_W-1:0]     CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0]     CH_MINUS  = 8'h2D;
	localparam logic [NIBBLE_W-1:0] ADJ_LIMIT = NIBBLE_W'(RADIX / 2);
	localparam logic [NIBBLE_W-1:0] ADJ_ADD   = NIBBLE_W'(((1 << NIBBLE_W) - RADIX) / 2);

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_DIGIT
	} state_t;

endpackage

// ----- hw/rtl/sitda_front.sv -----
// Front end: split an incoming integer into sign and unsigned magnitude.
module sitda_front (
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output sitda_pkg::item_t                     item
);

	logic [sitda_pkg::VALUE_W-1:0] raw;

	assign raw      = sitda_pkg::VALUE_W'(value);
	assign item.neg = raw[sitda_pkg::VALUE_W-1];
	// Take the magnitude as unsigned so the most negative value survives.
	assign item.mag = item.neg ? (sitda_pkg::VALUE_W'(0) - raw) : raw;

endmodule

// ----- hw/rtl/sitda_queue.sv -----
// Short request queue between the front end and the conversion back end.
module sitda_queue #(
	parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  sitda_pkg::item_t wr_item,
	output logic             full,
	input  logic             rd_en,
	output sitda_pkg::item_t rd_item,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sitda_pkg::item_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/sitda_back.sv -----
// Back end: binary to BCD conversion, four bits a cycle, then character output.
module sitda_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  sitda_pkg::item_t              q_item,
	output logic                          q_pop,
	output logic [sitda_pkg::CH_W-1:0]    ch,
	output logic                          last,
	output logic                          empty,
	input  logic                          pop
);

	localparam int VW = sitda_pkg::VALUE_W;
	localparam int BW = sitda_pkg::BCD_W;
	localparam int NW = sitda_pkg::NIBBLE_W;

	sitda_pkg::state_t            state_q;
	sitda_pkg::state_t            state_d;
	logic [VW-1:0]                bin_q;
	logic [BW-1:0]                bcd_q;
	logic [sitda_pkg::STEP_W-1:0] step_q;
	logic [sitda_pkg::POS_W-1:0]  pos_q;
	logic                         neg_q;
	logic                         out_valid_q;
	logic [sitda_pkg::CH_W-1:0]   ch_q;
	logic                         last_q;

	logic                         can_load;
	logic                         load_sign;
	logic                         load_digit;
	logic [VW-1:0]                bin_next;
	logic [BW-1:0]                bcd_next;
	logic [sitda_pkg::POS_W-1:0]  top_pos;
	logic [NW-1:0]                cur_digit;
	logic                         last_step;

	assign can_load  = !out_valid_q || pop;
	assign last_step = (step_q == sitda_pkg::STEP_W'(sitda_pkg::CONV_STEPS - 1));
	assign cur_digit = bcd_q[pos_q * NW +: NW];

	// Shift-add-3 over four bits: adjust every digit, then shift one bit in.
	always_comb begin
		logic [BW-1:0] b;
		logic [VW-1:0] s;
		b = bcd_q;
		s = bin_q;
		for (int j = 0; j < sitda_pkg::BITS_PER_STEP; j++) begin
			for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
				if (b[d*NW +: NW] >= sitda_pkg::ADJ_LIMIT) begin
					b[d*NW +: NW] = b[d*NW +: NW] + sitda_pkg::ADJ_ADD;
				end
			end
			b = {b[BW-2:0], s[VW-1]};
			s = {s[VW-2:0], 1'b0};
		end
		bcd_next = b;
		bin_next = s;
	end

	// Highest nonzero digit; zero gives position zero and prints one '0'.
	always_comb begin
		top_pos = '0;
		for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
			if (bcd_q[d*NW +: NW] != '0) begin
				top_pos = sitda_pkg::POS_W'(d);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (!q_empty) begin
					state_d = sitda_pkg::ST_CONV;
				end
			end
			sitda_pkg::ST_CONV: begin
				if (last_step) begin
					state_d = sitda_pkg::ST_FIND;
				end
			end
			sitda_pkg::ST_FIND: begin
				state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
			end
			sitda_pkg::ST_SIGN: begin
				if (can_load) begin
					state_d = sitda_pkg::ST_DIGIT;
				end
			end
			sitda_pkg::ST_DIGIT: begin
				if (can_load && pos_q == '0) begin
					state_d = sitda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		unique case (state_q)
			sitda_pkg::ST_IDLE:  q_pop      = !q_empty;
			sitda_pkg::ST_SIGN:  load_sign  = can_load;
			sitda_pkg::ST_DIGIT: load_digit = can_load;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sitda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				step_q <= '0;
			end else if (state_q == sitda_pkg::ST_CONV) begin
				step_q <= step_q + 1'b1;
			end
			if (load_sign || load_digit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bin_q <= q_item.mag;
			neg_q <= q_item.neg;
			bcd_q <= '0;
		end else if (state_q == sitda_pkg::ST_CONV) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end
		if (state_q == sitda_pkg::ST_FIND) begin
			pos_q <= top_pos;
		end else if (load_digit) begin
			pos_q <= pos_q - 1'b1;
		end
		if (load_sign) begin
			ch_q   <= sitda_pkg::CH_MINUS;
			last_q <= 1'b0;
		end else if (load_digit) begin
			ch_q   <= sitda_pkg::CH_ZERO + sitda_pkg::CH_W'(cur_digit);
			last_q <= (pos_q == '0);
		end
	end

	assign ch    = ch_q;
	assign last  = last_q;
	assign empty = !out_valid_q;

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Input queue side: present value and raise push; the request is taken at a
// clock edge where push is high and full is low. A short queue holds requests
// that wait for the converter.
// Output queue side: while empty is low, ch and last show the oldest pending
// character; it is taken at an edge where pop is high. Characters come most
// significant first, with a leading '-' for negative values and no leading
// zeros; last marks the final character of each number.
// Per number, the converter takes the request from the queue in its idle state,
// converts the magnitude to BCD four bits a cycle, finds the highest nonzero
// digit, then gives out the n characters of the text (n from 1 to 11).
// A stalled receiver holds the current character in the output register and
// the converter waits; new requests keep landing in the queue until it fills.
// Reset clears the queue, the converter state and the output valid flag.
module signed_int_to_decimal_ascii #(
	parameter int QUEUE_DEPTH = sitda_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                              empty,
	input  logic                              pop,
	output logic [sitda_pkg::CH_W-1:0]        ch,
	output logic                              last
);

	sitda_pkg::item_t in_item;
	sitda_pkg::item_t q_item;
	logic             q_empty;
	logic             q_pop;

	sitda_front u_front (
		.value (value),
		.item  (in_item)
	);

	sitda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (in_item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	sitda_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.ch      (ch),
		.last    (last),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

// ----- sim/signed_int_to_decimal_ascii_test.sv -----
// Testbench for the signed integer to decimal ASCII converter: queued requests, per-character check.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [sitda_pkg::CH_W-1:0] ch;
		logic                       last;
	} text_char_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  push;
	logic                                  full;
	logic signed [sitda_pkg::VALUE_W-1:0]  value;
	logic                                  empty;
	logic                                  pop;
	logic [sitda_pkg::CH_W-1:0]            ch;
	logic                                  last;

	text_char_t pending_chars[$];
	int         mismatches    = 0;
	int         values_sent   = 0;
	int         negatives     = 0;
	int         chars_checked = 0;
	int         cycle_count   = 0;
	bit         tx_idle_en    = 1'b0;
	bit         rx_stall_en   = 1'b0;

	signed_int_to_decimal_ascii u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.empty  (empty),
		.pop    (pop),
		.ch     (ch),
		.last   (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still due", cycle_count,
				pending_chars.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Queue the characters that the decimal text of v must produce.
	task automatic expect_decimal_text(input logic signed [sitda_pkg::VALUE_W-1:0] v);
		logic [sitda_pkg::VALUE_W-1:0]  mag;
		logic [sitda_pkg::NIBBLE_W-1:0] digit_buf [sitda_pkg::DIGITS];
		logic                           neg;
		int                             n;
		text_char_t                     c;
		neg = v[sitda_pkg::VALUE_W-1];
		mag = neg ? (~$unsigned(v) + 1'b1) : $unsigned(v);
		n = 0;
		do begin
			digit_buf[n] = sitda_pkg::NIBBLE_W'(mag % sitda_pkg::RADIX);
			mag = mag / sitda_pkg::RADIX;
			n++;
		end while (mag != 0);
		if (neg) begin
			c.ch = sitda_pkg::CH_MINUS;
			c.last = 1'b0;
			pending_chars.push_back(c);
			negatives++;
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.ch = sitda_pkg::CH_ZERO + sitda_pkg::CH_W'(digit_buf[i]);
			c.last = (i == 0);
			pending_chars.push_back(c);
		end
	endtask

	// Result side: compare each popped character with the oldest expectation.
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && !empty && pop) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character ch=%h last=%b", ch, last));
			end else begin
				exp_c = pending_chars.pop_front();
				chars_checked++;
				if (ch !== exp_c.ch)
					report_mismatch($sformatf("ch %h, want %h", ch, exp_c.ch));
				if (last !== exp_c.last)
					report_mismatch($sformatf("last %b, want %b (ch %h)", last, exp_c.last,
						exp_c.ch));
			end
		end
	end

	// Receiver: stall in random bursts while enabled.
	initial begin
		int gap;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall_en && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				pop = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	task automatic send_value(input logic signed [sitda_pkg::VALUE_W-1:0] v);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		push = 1'b1;
		value = v;
		do @(posedge clk); while (full);
		values_sent++;
		expect_decimal_text(v);
	endtask

	// Hold off new requests until every pending character has come out.
	task automatic wait_all_chars();
		@(negedge clk);
		push = 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Usually pick a value with a uniformly random digit count; one pick in eight is a raw random word.
	function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_value();
		longint lo;
		longint hi;
		longint mag;
		int     nd;
		logic   neg;
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		nd = $urandom_range(1, sitda_pkg::DIGITS);
		neg = 1'($urandom_range(0, 1));
		lo = 1;
		repeat (nd - 1) lo *= sitda_pkg::RADIX;
		hi = lo * sitda_pkg::RADIX - 1;
		if (nd == 1)
			lo = 0;
		if (neg && hi > 64'd2147483648)
			hi = 64'd2147483648;
		else if (!neg && hi > 64'd2147483647)
			hi = 64'd2147483647;
		mag = lo + longint'($urandom) % (hi - lo + 1);
		return neg ? sitda_pkg::VALUE_W'(-mag) : sitda_pkg::VALUE_W'(mag);
	endfunction

	task automatic test_edge_values();
		logic signed [sitda_pkg::VALUE_W-1:0] edge_vals[$];
		edge_vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd100,
			32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
			-32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd123456789,
			-32'sd987654321, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd1000000007};
		foreach (edge_vals[i])
			send_value(edge_vals[i]);
		wait_all_chars();
	endtask

	task automatic test_random_with_stalls();
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
		repeat (195) send_value(random_value());
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			repeat (5) send_value(random_value());
			wait_all_chars();
		end
	endtask

	task automatic test_back_to_back();
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		repeat (40) send_value(random_value());
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_edge_values();
		test_random_with_stalls();
		test_drain_pause();
		test_back_to_back();

		wait_all_chars();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("converted %0d values (%0d negative), %0d characters checked",
			values_sent, negatives, chars_checked);
		$display("covered edge values, random digit counts, both-side stalls, drain pauses");
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_queue.sv
hw/rtl/sitda_back.sv
hw/rtl/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_test.sv
